// ----- hdl/pwmt_pkg.sv -----
// Shared types and constants for the post/wait match table.
`default_nettype none
package pwmt_pkg;

  // Table geometry and field widths.
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = 6;
  localparam int unsigned NodeW      = 12;
  localparam int unsigned TagW       = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // Request kinds.
  localparam logic [1:0] ReqPost         = 2'd0;
  localparam logic [1:0] ReqWaitAny      = 2'd1;
  localparam logic [1:0] ReqWaitNode     = 2'd2;
  localparam logic [1:0] ReqWaitNodeTag  = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusNoMatch = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  localparam cnt_t CntFull = cnt_t'(TableDepth);

  // One request item.
  typedef struct packed {
    logic [1:0]              req_type;
    logic [NodeW-1:0]        node;
    logic signed [TagW-1:0]  tag;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    cnt_t        pending_count;
  } rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [TagW-1:0]  tag;
  } entry_t;

  // Access bundle from the sequencer to the entry memory.
  typedef struct packed {
    logic    rd_en;
    idx_t    rd_addr;
    logic    wr_en;
    idx_t    wr_addr;
    entry_t  wr_data;
  } ram_req_t;

endpackage
`default_nettype wire

// ----- hdl/pwmt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pwmt_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 44
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pwmt_ctrl.sv -----
// Request sequencer: appends, drops the newest on a wait-any, searches newest first and closes gaps in the table.
`default_nettype none
module pwmt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire pwmt_pkg::req_t    req_i,
  output logic                   done_o,
  output pwmt_pkg::rsp_t         rsp_o,
  output pwmt_pkg::ram_req_t     ram_o,
  input  wire pwmt_pkg::entry_t  ram_rdata_i
);
  import pwmt_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StShift
  } state_e;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  idx_t   idx_q, idx_d;
  req_t   req_q, req_d;
  logic   done_q, done_d;
  rsp_t   rsp_q, rsp_d;

  logic   match;
  cnt_t   pos_next;

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Compare of the entry read in the previous cycle against the held request.
  assign match = (ram_rdata_i.node == req_q.node) &&
                 ((req_q.req_type != ReqWaitNodeTag) ||
                  (ram_rdata_i.tag == $unsigned(req_q.tag)));

  assign pos_next = cnt_t'(idx_q) + cnt_t'(1);

  // Next-state and memory access logic.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    req_d   = req_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    ram_o   = '0;
    ram_o.wr_data = ram_rdata_i;

    case (state_q)
      StIdle: begin
        if (start) begin
          req_d = req_i;
          case (req_i.req_type)
            ReqPost: begin
              done_d = 1'b1;
              if (cnt_q >= CntFull) begin
                rsp_d = '{status: StatusFull, pending_count: cnt_q};
              end else begin
                ram_o.wr_en   = 1'b1;
                ram_o.wr_addr = idx_t'(cnt_q);
                ram_o.wr_data = '{node: req_i.node, tag: $unsigned(req_i.tag)};
                cnt_d = cnt_q + cnt_t'(1);
                rsp_d = '{status: StatusDone, pending_count: cnt_q + cnt_t'(1)};
              end
            end
            ReqWaitAny: begin
              done_d = 1'b1;
              if (cnt_q == '0) begin
                rsp_d = '{status: StatusNoMatch, pending_count: cnt_q};
              end else begin
                cnt_d = cnt_q - cnt_t'(1);
                rsp_d = '{status: StatusDone, pending_count: cnt_q - cnt_t'(1)};
              end
            end
            default: begin
              if (cnt_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{status: StatusNoMatch, pending_count: cnt_q};
              end else begin
                // Start the search at the newest entry.
                idx_d         = idx_t'(cnt_q - cnt_t'(1));
                ram_o.rd_en   = 1'b1;
                ram_o.rd_addr = idx_t'(cnt_q - cnt_t'(1));
                state_d       = StCmp;
              end
            end
          endcase
        end
      end

      StCmp: begin
        if (match) begin
          if (pos_next < cnt_q) begin
            // Fetch the entry above to move it down.
            ram_o.rd_en   = 1'b1;
            ram_o.rd_addr = idx_t'(pos_next);
            state_d       = StShift;
          end else begin
            cnt_d   = cnt_q - cnt_t'(1);
            done_d  = 1'b1;
            rsp_d   = '{status: StatusDone, pending_count: cnt_q - cnt_t'(1)};
            state_d = StIdle;
          end
        end else if (idx_q == '0) begin
          done_d  = 1'b1;
          rsp_d   = '{status: StatusNoMatch, pending_count: cnt_q};
          state_d = StIdle;
        end else begin
          idx_d         = idx_q - idx_t'(1);
          ram_o.rd_en   = 1'b1;
          ram_o.rd_addr = idx_q - idx_t'(1);
        end
      end

      StShift: begin
        // The entry read from one place up is written to the gap.
        ram_o.wr_en   = 1'b1;
        ram_o.wr_addr = idx_q;
        ram_o.wr_data = ram_rdata_i;
        idx_d         = idx_t'(pos_next);
        if ((pos_next + cnt_t'(1)) < cnt_q) begin
          ram_o.rd_en   = 1'b1;
          ram_o.rd_addr = idx_t'(pos_next + cnt_t'(1));
        end else begin
          cnt_d   = cnt_q - cnt_t'(1);
          done_d  = 1'b1;
          rsp_d   = '{status: StatusDone, pending_count: cnt_q - cnt_t'(1)};
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      idx_q   <= '0;
      req_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      req_q   <= req_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  // The count never goes past the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("entry count above table depth");

  // A result is only issued when the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (state_q == StIdle))
    else $error("result issued while still working");

  // While shifting, the entry being moved lies inside the held range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StShift) |-> (pos_next < cnt_q))
    else $error("shift outside the held entries");

  // A result whose strobe rises has moved the count by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(done_q) |-> ((cnt_q == $past(cnt_q)) ||
                                      (cnt_q == $past(cnt_q) + cnt_t'(1)) ||
                                      (cnt_q == $past(cnt_q) - cnt_t'(1))))
    else $error("count moved by more than one");

  // A full report leaves the count at the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_q && (rsp_q.status == StatusFull)) |-> (cnt_q == CntFull))
    else $error("full reported while table has room");

endmodule
`default_nettype wire

// ----- hdl/post_wait_match_table.sv -----
// Top level of the post/wait match table: sequencer plus entry memory.
//
//   channel   handshake            payload        direction
//   request   start & !busy        req_i          in
//   result    done_o (one cycle)   rsp_o          out
//
// A post or a wait-any is served from idle: the result strobe follows at the next edge.
// A wait by node or by node and tag scans the entry memory newest first, one entry
// per cycle through its single read port, then moves each entry above the match down
// one place, one per cycle.
// Reset clears the count and sequencer registers, not the entry memory; it needs no clearing pass.
// The receiver cannot stall; busy holds off new items while a search or shift runs.
`default_nettype none
module post_wait_match_table (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire pwmt_pkg::req_t  req_i,
  output logic                 done_o,
  output pwmt_pkg::rsp_t       rsp_o
);
  import pwmt_pkg::*;

  ram_req_t ram_req;
  entry_t   ram_rdata;

  // Request sequencer.
  pwmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Entry memory holding node and tag of each pending post.
  pwmt_ram #(
    .Depth (TableDepth),
    .Width ($bits(entry_t))
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rdata),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data)
  );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the post/wait match table.
`default_nettype none
module tb_top;
  import pwmt_pkg::*;

  localparam int unsigned NumRandomItems = 1750;
  localparam int unsigned DrainCycles    = 100;
  localparam int unsigned CycleLimit     = 700_000;
  localparam int unsigned MaxReported    = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_item = '0;
  logic rsp_valid;
  rsp_t rsp_item;

  // Items waiting to be offered, and the results the table should still produce.
  req_t   pending_req_q[$];
  rsp_t   expected_rsp_q[$];
  // Entries the table should hold, and the entries the stimulus plan assumes.
  entry_t held_entries_q[$];
  entry_t plan_entries_q[$];

  int unsigned cycle_cnt  = 0;
  int unsigned fail_cnt   = 0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  int unsigned req_seen[4];
  int unsigned status_seen[4];

  post_wait_match_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_item),
    .done_o (rsp_valid),
    .rsp_o  (rsp_item)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one request to a table image and return the result it causes.
  // Waits search from the newest entry down; deleting from the queue keeps age order.
  function automatic rsp_t serve_request(ref entry_t tbl[$], input req_t r);
    rsp_t   rsp;
    entry_t e;
    int     hit;
    hit        = -1;
    rsp.status = StatusDone;
    case (r.req_type)
      ReqPost: begin
        if (tbl.size() >= TableDepth) begin
          rsp.status = StatusFull;
        end else begin
          e.node = r.node;
          e.tag  = r.tag;
          tbl.push_back(e);
        end
      end
      ReqWaitAny: begin
        if (tbl.size() == 0) begin
          rsp.status = StatusNoMatch;
        end else begin
          void'(tbl.pop_back());
        end
      end
      default: begin
        for (int i = tbl.size() - 1; i >= 0; i--) begin
          if (hit < 0 && tbl[i].node == r.node &&
              (r.req_type == ReqWaitNode || tbl[i].tag == r.tag)) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          rsp.status = StatusNoMatch;
        end else begin
          tbl.delete(hit);
        end
      end
    endcase
    rsp.pending_count = cnt_t'(tbl.size());
    return rsp;
  endfunction

  // Queue one item and track the table contents it leaves behind.
  task automatic plan_item(input logic [1:0] kind, input logic [NodeW-1:0] nd,
                           input logic [TagW-1:0] tg);
    req_t r;
    r.req_type = kind;
    r.node     = nd;
    r.tag      = tg;
    pending_req_q.push_back(r);
    void'(serve_request(plan_entries_q, r));
  endtask

  // Stimulus plan, reset, and end of run.
  initial begin : stimulus
    int unsigned      planned;
    int unsigned      mode;
    int unsigned      seg_len;
    int unsigned      post_pct;
    int unsigned      roll;
    int unsigned      k;
    logic [1:0]       kind;
    logic [NodeW-1:0] nd;
    logic [TagW-1:0]  tg;

    // Directed part: empty table, field extremes, tag and node near misses,
    // newest-first matching, removal of the oldest entry, ignored fields.
    plan_item(ReqWaitAny,     '0,             '0);
    plan_item(ReqWaitNode,    '0,             '0);
    plan_item(ReqWaitNodeTag, '1,             '1);
    plan_item(ReqPost,        '0,             32'h8000_0000);
    plan_item(ReqPost,        '1,             32'h7FFF_FFFF);
    plan_item(ReqPost,        12'hAAA,        32'h5555_5555);
    plan_item(ReqPost,        12'h555,        32'hAAAA_AAAA);
    plan_item(ReqPost,        '0,             32'hFFFF_FFFF);
    plan_item(ReqPost,        '0,             32'h0000_0000);
    plan_item(ReqWaitNodeTag, '1,             32'h0000_0000);
    plan_item(ReqWaitNodeTag, 12'h123,        32'h7FFF_FFFF);
    plan_item(ReqWaitNode,    '0,             32'h1234_5678);
    plan_item(ReqWaitNodeTag, '0,             32'h8000_0000);
    plan_item(ReqWaitNode,    12'hAAA,        32'hDEAD_BEEF);
    plan_item(ReqWaitAny,     '1,             '1);
    plan_item(ReqWaitNode,    12'h555,        '0);
    plan_item(ReqWaitNodeTag, '1,             32'h7FFF_FFFF);
    plan_item(ReqWaitAny,     12'h0F0,        32'h0F0F_0F0F);
    plan_item(ReqWaitAny,     '0,             '0);
    plan_item(ReqPost,        12'h7FF,        32'h0000_0001);
    plan_item(ReqWaitNodeTag, 12'h7FF,        32'h0000_0001);

    // Random part in segments that lean toward filling, draining or mixing,
    // so the table swings between empty and full. Most waits target held entries.
    planned = 0;
    while (planned < NumRandomItems) begin
      mode     = $urandom_range(0, 2);
      seg_len  = $urandom_range(10, 80);
      post_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < post_pct) begin
          kind = ReqPost;
          nd   = ($urandom_range(0, 3) == 0) ? NodeW'($urandom) : NodeW'($urandom_range(0, 7));
          tg   = ($urandom_range(0, 1) == 0) ? $urandom : TagW'($urandom_range(0, 3));
        end else if (roll < post_pct + 6 || plan_entries_q.size() == 0 ||
                     $urandom_range(0, 9) < 2) begin
          // Noise: any kind with arbitrary fields.
          kind = 2'($urandom_range(0, 3));
          nd   = NodeW'($urandom);
          tg   = $urandom;
        end else begin
          kind = 2'($urandom_range(1, 3));
          k    = $urandom_range(0, plan_entries_q.size() - 1);
          nd   = plan_entries_q[k].node;
          tg   = plan_entries_q[k].tag;
          // Sometimes borrow the tag of another entry for a near miss.
          if ($urandom_range(0, 4) == 0) begin
            tg = plan_entries_q[$urandom_range(0, plan_entries_q.size() - 1)].tag;
          end
        end
        plan_item(kind, nd, tg);
        planned++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every item is taken and every result has come back.
    while (pending_req_q.size() != 0 || expected_rsp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d posts, %0d wait-any, %0d wait-by-node, %0d wait-by-node-and-tag.",
             req_seen[ReqPost], req_seen[ReqWaitAny], req_seen[ReqWaitNode],
             req_seen[ReqWaitNodeTag]);
    $display("Results seen: %0d done, %0d no match, %0d table full; %0d failures.",
             status_seen[StatusDone], status_seen[StatusNoMatch], status_seen[StatusFull],
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Request driver: offers queued items in bursts separated by random gaps.
  always @(posedge clk_i) begin : driver
    logic accepted;
    if (rst_ni) begin
      accepted = start && !busy;
      if (accepted) begin
        void'(pending_req_q.pop_front());
      end
      if (!start || accepted) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          start    <= 1'b1;
          req_item <= pending_req_q[0];
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
            gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each strobed result, then predicts for the item taken
  // at this edge. A result never returns at the edge that takes its item.
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid) begin
        if (rsp_item.status <= StatusFull) status_seen[rsp_item.status]++;
        if (expected_rsp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReported) begin
            $display("[%0d] result with none expected: status %0d count %0d",
                     cycle_cnt, rsp_item.status, rsp_item.pending_count);
          end
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_item.status !== want.status ||
              rsp_item.pending_count !== want.pending_count) begin
            fail_cnt++;
            if (fail_cnt <= MaxReported) begin
              $display("[%0d] mismatch: status %0d (want %0d), count %0d (want %0d)",
                       cycle_cnt, rsp_item.status, want.status,
                       rsp_item.pending_count, want.pending_count);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_rsp_q.push_back(serve_request(held_entries_q, req_item));
        req_seen[req_item.req_type]++;
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d items unsent, %0d results outstanding.",
               cycle_cnt, pending_req_q.size(), expected_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
`default_nettype wire
